/* rtl/acfpc_pkg.sv */
// ----------------------------------------------------------------------------
// acfpc_pkg: shared definitions for the clock face pixel classifier
// Beat kinds, color classes, field widths and the time keeper control bundle.
// ----------------------------------------------------------------------------
package acfpc_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned COORD_W = 6;
    localparam int unsigned HOUR_W  = 4;
    localparam int unsigned MS_W    = 6;
    localparam int unsigned LHOUR_W = 5;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned IN_W    = 2 * COORD_W + LHOUR_W + 2 * MS_W;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

    localparam logic [CLASS_W-1:0] CLS_RING       = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_SHADOW     = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_SECOND     = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_MINUTE     = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_HOUR       = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_TICK       = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_CENTER     = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_FACE       = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_BACKGROUND = 4'd8;

    // Hand slopes are signed Q5.16; vertical hands saturate.
    localparam logic signed [21:0] COT_SAT        = 22'sd2097151;
    localparam logic signed [21:0] COT_WIDE_LIMIT = 22'sd393216;

    typedef struct packed {
        logic tick;
        logic load;
    } t_time_ctl;

endpackage

/* rtl/acfpc_time.sv */
// ----------------------------------------------------------------------------
// acfpc_time: time of day keeper
// Holds hour, minute and second; advances by one second or loads a new time.
// ----------------------------------------------------------------------------
module acfpc_time
    import acfpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_time_ctl         i_ctl,
    input  logic [LHOUR_W-1:0] i_load_hour,
    input  logic [MS_W-1:0]   i_load_minute,
    input  logic [MS_W-1:0]   i_load_second,
    output logic [MS_W-1:0]   o_second,
    output logic [MS_W-1:0]   o_minute,
    output logic [HOUR_W-1:0] o_hour
);

    logic [MS_W-1:0]   r_sec, n_sec;
    logic [MS_W-1:0]   r_min, n_min;
    logic [HOUR_W-1:0] r_hour, n_hour;
    logic [LHOUR_W-1:0] hour_mod;

    always_comb begin
        if (i_load_hour >= 5'd24) begin
            hour_mod = i_load_hour - 5'd24;
        end else if (i_load_hour >= 5'd12) begin
            hour_mod = i_load_hour - 5'd12;
        end else begin
            hour_mod = i_load_hour;
        end
    end

    always_comb begin
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        if (i_ctl.load) begin
            n_hour = hour_mod[HOUR_W-1:0];
            n_min  = (i_load_minute >= 6'd60) ? i_load_minute - 6'd60 : i_load_minute;
            n_sec  = (i_load_second >= 6'd60) ? i_load_second - 6'd60 : i_load_second;
        end else if (i_ctl.tick) begin
            if (r_sec >= 6'd59) begin
                n_sec = '0;
                if (r_min >= 6'd59) begin
                    n_min  = '0;
                    n_hour = (r_hour >= 4'd11) ? '0 : r_hour + 4'd1;
                end else begin
                    n_min = r_min + 6'd1;
                end
            end else begin
                n_sec = r_sec + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= '0;
            r_min  <= '0;
            r_hour <= '0;
        end else begin
            r_sec  <= n_sec;
            r_min  <= n_min;
            r_hour <= n_hour;
        end
    end

    assign o_second = r_sec;
    assign o_minute = r_min;
    assign o_hour   = r_hour;

    a_sec_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.tick && !i_ctl.load && r_sec == 6'd59 |=> r_sec == 6'd0)
        else $error("second did not wrap");

    a_sec_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.tick && !i_ctl.load && r_sec < 6'd59 |=>
        r_sec == $past(r_sec) + 6'd1 && $stable(r_min))
        else $error("second did not advance alone");

    a_min_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.tick && !i_ctl.load && r_sec == 6'd59 && r_min < 6'd59 |=>
        r_min == $past(r_min) + 6'd1 && $stable(r_hour))
        else $error("minute carry wrong");

endmodule

/* rtl/acfpc_classify.sv */
// ----------------------------------------------------------------------------
// acfpc_classify: pixel classifier
// Tests one pixel against ring, shadow, hands, ticks, center and face.
// ----------------------------------------------------------------------------
module acfpc_classify
    import acfpc_pkg::*;
(
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic [MS_W-1:0]           i_second,
    input  logic [MS_W-1:0]           i_minute,
    input  logic [HOUR_W-1:0]         i_hour,
    output logic [CLASS_W-1:0]        o_class
);

    function automatic logic signed [21:0] cot_lookup(input logic [5:0] k);
        logic [5:0] j;
        logic signed [21:0] v;
        j = (k >= 6'd30) ? k - 6'd30 : k;
        case (j)
            6'd0:  v = (k >= 6'd30) ? -COT_SAT : COT_SAT;
            6'd1:  v = 22'sd623533;
            6'd2:  v = 22'sd308323;
            6'd3:  v = 22'sd201699;
            6'd4:  v = 22'sd147196;
            6'd5:  v = 22'sd113512;
            6'd6:  v = 22'sd90203;
            6'd7:  v = 22'sd72785;
            6'd8:  v = 22'sd59009;
            6'd9:  v = 22'sd47615;
            6'd10: v = 22'sd37837;
            6'd11: v = 22'sd29179;
            6'd12: v = 22'sd21294;
            6'd13: v = 22'sd13930;
            6'd14: v = 22'sd6888;
            6'd15: v = 22'sd0;
            6'd16: v = -22'sd6888;
            6'd17: v = -22'sd13930;
            6'd18: v = -22'sd21294;
            6'd19: v = -22'sd29179;
            6'd20: v = -22'sd37837;
            6'd21: v = -22'sd47615;
            6'd22: v = -22'sd59009;
            6'd23: v = -22'sd72785;
            6'd24: v = -22'sd90203;
            6'd25: v = -22'sd113512;
            6'd26: v = -22'sd147196;
            6'd27: v = -22'sd201699;
            6'd28: v = -22'sd308323;
            6'd29: v = -22'sd623533;
            default: v = 22'sd0;
        endcase
        return v;
    endfunction

    function automatic logic on_band(input logic signed [21:0] slope,
                                     input logic [3:0] w,
                                     input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
        logic signed [28:0] p;
        logic signed [7:0]  ylo;
        logic signed [7:0]  yhi;
        logic signed [28:0] lo;
        logic signed [28:0] hi;
        p   = slope * x;
        ylo = 8'(y) - 8'({4'b0, w});
        yhi = 8'(y) + 8'({4'b0, w});
        lo  = {{5{ylo[7]}}, ylo, 16'b0};
        hi  = {{5{yhi[7]}}, yhi, 16'b0};
        return (p > lo) && (p < hi);
    endfunction

    function automatic logic hand_hit(input logic [5:0] k,
                                      input logic signed [13:0] r2,
                                      input logic signed [13:0] d,
                                      input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
        logic signed [21:0] t;
        logic [3:0] w;
        logic band;
        logic hit;
        t    = cot_lookup(k);
        w    = (t >= COT_WIDE_LIMIT || t <= -COT_WIDE_LIMIT) ? 4'd10 : 4'd1;
        band = on_band(t, w, x, y);
        hit  = (band && x > 0 && k < 6'd30) || (band && x < 0 && k > 6'd30) ||
               (x == 0 && y > 0 && k == 6'd0) || (x == 0 && y < 0 && k == 6'd30);
        return (d <= r2) && hit;
    endfunction

    logic signed [6:0]  xm;
    logic signed [6:0]  yp;
    logic signed [13:0] xsq, ysq, xmsq, ypsq;
    logic signed [13:0] d, ds;
    logic [5:0]         hour_pos;
    logic               tick_ring, tick_band;

    assign xm   = 7'(i_x) - 7'sd1;
    assign yp   = 7'(i_y) + 7'sd1;
    assign xsq  = i_x * i_x;
    assign ysq  = i_y * i_y;
    assign xmsq = xm * xm;
    assign ypsq = yp * yp;
    assign d    = xsq + ysq;
    assign ds   = xmsq + ypsq;
    assign hour_pos  = {i_hour, 2'b00} + {2'b00, i_hour};
    assign tick_ring = (d >= 14'sd520) && (d <= 14'sd600);
    assign tick_band = on_band(cot_lookup(6'd25), 4'd1, i_x, i_y) ||
                       on_band(cot_lookup(6'd20), 4'd1, i_x, i_y) ||
                       on_band(cot_lookup(6'd10), 4'd1, i_x, i_y) ||
                       on_band(cot_lookup(6'd5), 4'd1, i_x, i_y);

    always_comb begin
        if (d >= 14'sd600 && d <= 14'sd700) begin
            o_class = CLS_RING;
        end else if (ds >= 14'sd600 && ds <= 14'sd700) begin
            o_class = CLS_SHADOW;
        end else if (hand_hit(i_second, 14'sd400, d, i_x, i_y)) begin
            o_class = CLS_SECOND;
        end else if (hand_hit(i_minute, 14'sd300, d, i_x, i_y)) begin
            o_class = CLS_MINUTE;
        end else if (hand_hit(hour_pos, 14'sd200, d, i_x, i_y)) begin
            o_class = CLS_HOUR;
        end else if (tick_ring && (((i_x == 0) != (i_y == 0)) || tick_band)) begin
            o_class = CLS_TICK;
        end else if (i_x == 0 && i_y == 0) begin
            o_class = CLS_CENTER;
        end else if (d <= 14'sd600) begin
            o_class = CLS_FACE;
        end else begin
            o_class = CLS_BACKGROUND;
        end
    end

endmodule

/* rtl/analog_clock_face_pixel_classifier_unit.sv */
// ----------------------------------------------------------------------------
// analog_clock_face_pixel_classifier_unit: clock face pixel classifier
// Keeps a 12-hour time and returns the color class of each queried pixel.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: kind; tdata: px, py, load_hour, load_minute, load_second
// m_axis    out  tdata: color_class (one beat per pixel query only)
//
// One beat enters per cycle unless a pixel query waits on a stalled result;
// a pixel query's result passes one input register and one result register.
// Tick and load beats update the time as they leave the input register.
// Reset clears the time to 00:00:00 and empties both registers.
// A stalled result holds a pixel query and every beat behind it; other beats flow.
// ----------------------------------------------------------------------------
module analog_clock_face_pixel_classifier_unit
    import acfpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // px, py, load_hour, load_minute, load_second, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // color_class, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic                 r_in_valid;
    logic [KIND_W-1:0]    r_in_kind;
    logic [IN_W-1:0]      r_in_data;
    logic                 r_out_valid;
    logic [CLASS_W-1:0]   r_out_class;
    logic                 advance;
    t_time_ctl            time_ctl;
    logic [MS_W-1:0]      cur_sec, cur_min;
    logic [HOUR_W-1:0]    cur_hour;
    logic [CLASS_W-1:0]   pix_class;

    assign advance = r_in_valid &&
                     (r_in_kind != KIND_PIXEL || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        time_ctl = '0;
        case (r_in_kind)
            KIND_TICK: time_ctl.tick = advance;
            KIND_LOAD: time_ctl.load = advance;
            default:   time_ctl = '0;
        endcase
    end

    acfpc_time u_time (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (time_ctl),
        .i_load_hour   (r_in_data[16:12]),
        .i_load_minute (r_in_data[22:17]),
        .i_load_second (r_in_data[28:23]),
        .o_second      (cur_sec),
        .o_minute      (cur_min),
        .o_hour        (cur_hour)
    );

    acfpc_classify u_classify (
        .i_x      (signed'(r_in_data[5:0])),
        .i_y      (signed'(r_in_data[11:6])),
        .i_second (cur_sec),
        .i_minute (cur_min),
        .i_hour   (cur_hour),
        .o_class  (pix_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance && r_in_kind == KIND_PIXEL) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata[IN_W-1:0];
        end
        if (advance && r_in_kind == KIND_PIXEL) begin
            r_out_class <= pix_class;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - CLASS_W){1'b0}}, r_out_class};

endmodule

/* verif/analog_clock_face_pixel_classifier_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_clock_face_pixel_classifier_unit_tb: self-checking bench for the
// clock face pixel classifier.
// Drives pixel queries, second ticks, time loads and unused kinds on the input
// stream. The bench keeps its own copy of the time of day and computes the
// expected color class of every accepted pixel. Each output beat is compared
// against the oldest pending class. Both stream sides stall at random, and the
// output side also holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module analog_clock_face_pixel_classifier_unit_tb;
    import acfpc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam longint RING_LO    = 600;
    localparam longint RING_HI    = 700;
    localparam longint TICK_LO    = 520;
    localparam longint SEC_R2     = 400;
    localparam longint MIN_R2     = 300;
    localparam longint HOUR_R2    = 200;
    localparam longint Q16_ONE    = 65536;
    localparam longint WIDE_LIMIT = 6 * 65536;
    localparam int     SLOPE_SAT  = 2097151;
    localparam int     RANDOM_ITEMS = 400;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     LIMIT_CYCLES = 60000;

    // Slope of a hand at each of the 60 positions, cot(k * 6 deg) in Q5.16.
    localparam int COT_Q16 [60] = '{
        SLOPE_SAT, 623533, 308323, 201699, 147196, 113512, 90203, 72785, 59009, 47615,
        37837, 29179, 21294, 13930, 6888, 0, -6888, -13930, -21294, -29179,
        -37837, -47615, -59009, -72785, -90203, -113512, -147196, -201699, -308323,
        -623533,
        -SLOPE_SAT, 623533, 308323, 201699, 147196, 113512, 90203, 72785, 59009, 47615,
        37837, 29179, 21294, 13930, 6888, 0, -6888, -13930, -21294, -29179,
        -37837, -47615, -59009, -72785, -90203, -113512, -147196, -201699, -308323,
        -623533
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = KIND_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [MS_W-1:0]       sec_now = '0;
    logic [MS_W-1:0]       min_now = '0;
    logic [HOUR_W-1:0]     hr_now = '0;
    logic [CLASS_W-1:0]    pending_class_q [$];

    bit steady = 1'b0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    analog_clock_face_pixel_classifier_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("analog_clock_face_pixel_classifier_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic bit in_band(input longint slope, input longint w, input longint x,
                                   input longint y);
        longint p;
        p = slope * x;
        return (p > (y - w) * Q16_ONE) && (p < (y + w) * Q16_ONE);
    endfunction

    function automatic bit hand_covers(input int k, input longint r2, input longint x,
                                       input longint y, input longint d);
        longint t;
        longint w;
        bit band;
        if (d > r2)
            return 1'b0;
        t = COT_Q16[k % 60];
        w = (t >= WIDE_LIMIT || t <= -WIDE_LIMIT) ? 10 : 1;
        band = in_band(t, w, x, y);
        return (band && x > 0 && k < 30) || (band && x < 0 && k > 30) ||
               (x == 0 && y > 0 && k == 0) || (x == 0 && y < 0 && k == 30);
    endfunction

    function automatic logic [CLASS_W-1:0] predict_class(input logic signed [COORD_W-1:0] px,
                                                         input logic signed [COORD_W-1:0] py);
        longint x;
        longint y;
        longint d;
        longint ds;
        bit tick_ring;
        x = px;
        y = py;
        d = x * x + y * y;
        ds = (x - 1) * (x - 1) + (y + 1) * (y + 1);
        tick_ring = d >= TICK_LO && d <= RING_LO;
        if (d >= RING_LO && d <= RING_HI)
            return CLS_RING;
        if (ds >= RING_LO && ds <= RING_HI)
            return CLS_SHADOW;
        if (hand_covers(int'(sec_now), SEC_R2, x, y, d))
            return CLS_SECOND;
        if (hand_covers(int'(min_now), MIN_R2, x, y, d))
            return CLS_MINUTE;
        if (hand_covers(5 * int'(hr_now), HOUR_R2, x, y, d))
            return CLS_HOUR;
        if (tick_ring && ((x == 0) != (y == 0)))
            return CLS_TICK;
        if (tick_ring && (in_band(COT_Q16[25], 1, x, y) || in_band(COT_Q16[20], 1, x, y) ||
                          in_band(COT_Q16[10], 1, x, y) || in_band(COT_Q16[5], 1, x, y)))
            return CLS_TICK;
        if (x == 0 && y == 0)
            return CLS_CENTER;
        if (d <= RING_LO)
            return CLS_FACE;
        return CLS_BACKGROUND;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_fields(input logic [COORD_W-1:0] px,
                                                         input logic [COORD_W-1:0] py,
                                                         input logic [LHOUR_W-1:0] lh,
                                                         input logic [MS_W-1:0] lm,
                                                         input logic [MS_W-1:0] ls);
        return {{(IN_DATA_W - IN_W){1'b0}}, ls, lm, lh, py, px};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_fields();
        return pack_fields(COORD_W'($urandom), COORD_W'($urandom), LHOUR_W'($urandom),
                           MS_W'($urandom), MS_W'($urandom));
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
        logic [MS_W-1:0] lm;
        logic [MS_W-1:0] ls;
        while (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (kind)
            KIND_PIXEL: begin
                pending_class_q.push_back(predict_class(data[5:0], data[11:6]));
            end
            KIND_TICK: begin
                if (sec_now >= 59) begin
                    sec_now = '0;
                    if (min_now >= 59) begin
                        min_now = '0;
                        hr_now = (hr_now >= 11) ? '0 : hr_now + 1'b1;
                    end else begin
                        min_now = min_now + 1'b1;
                    end
                end else begin
                    sec_now = sec_now + 1'b1;
                end
            end
            KIND_LOAD: begin
                lm = data[22:17];
                ls = data[28:23];
                hr_now  = HOUR_W'(data[16:12] % 12);
                min_now = (lm >= 60) ? lm - 6'd60 : lm;
                sec_now = (ls >= 60) ? ls - 6'd60 : ls;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_pixel(input int x, input int y);
        send_beat(KIND_PIXEL, pack_fields(x[5:0], y[5:0], LHOUR_W'($urandom),
                                          MS_W'($urandom), MS_W'($urandom)));
    endtask

    task automatic send_tick();
        send_beat(KIND_TICK, random_fields());
    endtask

    task automatic send_load(input int h, input int m, input int s);
        send_beat(KIND_LOAD, pack_fields(COORD_W'($urandom), COORD_W'($urandom), h[4:0],
                                         m[5:0], s[5:0]));
    endtask

    // Output side: checks every beat and decides the next ready.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_class_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: class %0d", m_tdata[CLASS_W-1:0]);
            end else begin
                if (m_tdata[CLASS_W-1:0] != pending_class_q[0]) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("class mismatch: expected %0d, actual %0d",
                                 pending_class_q[0], m_tdata[CLASS_W-1:0]);
                end
                void'(pending_class_q.pop_front());
            end
        end
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    task automatic test_reset_time();
        send_pixel(0, 0);
        send_pixel(0, 15);
        send_pixel(15, 0);
        send_pixel(-28, -28);
        send_pixel(28, 28);
        send_pixel(-32, -32);
        send_pixel(31, 31);
        send_pixel(-32, 31);
    endtask

    task automatic test_load_wrap();
        send_load(23, 63, 63);
        send_pixel(5, 10);
        send_load(12, 60, 60);
        send_pixel(-10, -3);
    endtask

    task automatic test_tick_carry();
        send_load(11, 59, 58);
        send_tick();
        send_pixel(-3, 12);
        send_tick();
        send_pixel(0, 12);
    endtask

    task automatic test_unused_kind();
        send_beat(KIND_SPARE, random_fields());
        send_pixel(0, 12);
    endtask

    task automatic test_hand_directions();
        send_load(3, 30, 45);
        send_pixel(10, 0);
        send_pixel(0, -10);
        send_pixel(-10, 0);
    endtask

    task automatic test_backpressure();
        hold_seq++;
        for (int i = 0; i < 24; i++)
            send_pixel($urandom_range(0, 56) - 28, $urandom_range(0, 56) - 28);
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        int roll;
        int k;
        int ax;
        int ay;
        longint prod;
        n = 0;
        while (n < count) begin
            steady = (n >= count / 3) && (n < count / 3 + 100);
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_beat(KIND_SPARE, random_fields());
                continue;
            end
            n++;
            if (roll < 13) begin
                if ($urandom_range(99) < 30)
                    send_load($urandom_range(0, 31), 59, $urandom_range(56, 59));
                else
                    send_load($urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom_range(0, 63));
            end else if (roll < 25) begin
                send_tick();
            end else begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    // Aim at one of the hands so that the narrow bands get hit.
                    case ($urandom_range(2))
                        0: k = int'(sec_now);
                        1: k = int'(min_now);
                        default: k = 5 * int'(hr_now);
                    endcase
                    if (k == 0 || k == 30) begin
                        ax = $urandom_range(0, 2) - 1;
                        ay = $urandom_range(1, 20);
                        if (k == 30)
                            ay = -ay;
                    end else begin
                        ax = $urandom_range(1, 20);
                        if (k > 30)
                            ax = -ax;
                        prod = longint'(COT_Q16[k]) * ax;
                        ay = int'(prod / Q16_ONE) + $urandom_range(0, 4) - 2;
                        if (ay > 28)
                            ay = 28;
                        if (ay < -28)
                            ay = -28;
                    end
                    send_pixel(ax, ay);
                end else if (roll < 90) begin
                    send_pixel($urandom_range(0, 56) - 28, $urandom_range(0, 56) - 28);
                end else begin
                    send_pixel($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32);
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_time();
        test_load_wrap();
        test_tick_carry();
        test_unused_kind();
        test_hand_directions();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (pending_class_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("analog_clock_face_pixel_classifier_unit_tb: PASS");
        end else begin
            $display("analog_clock_face_pixel_classifier_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
